@@ rtl/nbge_pkg.sv @@
// ============================================================================
// nbge_pkg
// Shared constants and types for the gravity Euler step block.
// ============================================================================
package nbge_pkg;

    localparam int WORD_W      = 32;
    localparam int DT_W        = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int FRAC_BITS_D = 16;
    localparam int NORM_BITS   = 24;
    localparam int GRAV_CONST  = 15;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_POS_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POS_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POS_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VEL_X  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VEL_Y  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_VEL_Z  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MASS   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_STATIC = 3'd7;

    typedef struct packed {
        logic                 action;
        logic signed [31:0]   other_x;
        logic signed [31:0]   other_y;
        logic signed [31:0]   other_z;
        logic        [31:0]   other_mass;
        logic        [15:0]   step_time;
        logic                 is_self;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0]   pos_x;
        logic signed [31:0]   pos_y;
        logic signed [31:0]   pos_z;
        logic signed [31:0]   vel_x;
        logic signed [31:0]   vel_y;
        logic signed [31:0]   vel_z;
        logic                 singular;
    } out_item_t;

    // Shared divide/root unit command and status
    typedef enum logic [1:0] {
        OP_SQRT = 2'd0,
        OP_DIV  = 2'd1
    } iter_op_t;

    typedef struct packed {
        logic     start;
        iter_op_t op;
    } iter_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } iter_stat_t;

endpackage

@@ rtl/nbge_if.sv @@
// ============================================================================
// nbge_if
// Valid/ready channel carrying one payload item.
// ============================================================================
interface nbge_if #(
    parameter type PAYLOAD_T = logic
);
    logic     valid;
    logic     ready;
    PAYLOAD_T payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/nbge_iter.sv @@
// ============================================================================
// nbge_iter
// Shared iterative unit: 64-bit integer square root or 64/64 division,
// two result bits per cycle.
// ============================================================================
module nbge_iter
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  nbge_pkg::iter_cmd_t  cmd,
    input  logic [63:0]          opa,
    input  logic [63:0]          opb,
    output nbge_pkg::iter_stat_t stat,
    output logic [63:0]          result
);
    import nbge_pkg::*;

    logic [63:0] rem_reg, rem_next;
    logic [63:0] quo_reg, quo_next;
    logic [63:0] num_reg, num_next;
    logic [63:0] den_reg;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, done_reg;
    iter_op_t    op_reg;

    // One restoring step per call, two calls per cycle
    always_comb
    begin
        logic [64:0] trial;
        logic [63:0] r;
        logic [63:0] qv;
        logic [63:0] n;
        logic        nb;
        r  = rem_reg;
        qv = quo_reg;
        n  = num_reg;
        trial = '0;
        nb = 1'b0;
        for (int s = 0; s < 2; s++)
        begin
            if (op_reg == OP_DIV)
            begin
                // bring down the next dividend bit
                nb    = n[63];
                trial = {r, nb} - {1'b0, den_reg};
                n     = {n[62:0], 1'b0};
                if (!trial[64])
                begin
                    r  = trial[63:0];
                    qv = {qv[62:0], 1'b1};
                end
                else
                begin
                    r  = {r[62:0], nb};
                    qv = {qv[62:0], 1'b0};
                end
            end
            else
            begin
                // digit-by-digit root: bring down two bits
                trial = {1'b0, r[61:0], n[63:62]} - {1'b0, qv[61:0], 2'b01};
                if (!trial[64])
                begin
                    r  = trial[63:0];
                    qv = {qv[62:0], 1'b1};
                end
                else
                begin
                    r  = {r[61:0], n[63:62]};
                    qv = {qv[62:0], 1'b0};
                end
                n = {n[61:0], 2'b00};
            end
        end
        rem_next = r;
        quo_next = qv;
        num_next = n;
        cnt_next = cnt_reg - 6'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= OP_SQRT;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                busy_reg <= 1'b1;
                op_reg   <= cmd.op;
                cnt_reg  <= (cmd.op == OP_DIV) ? 6'd31 : 6'd15;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_next;
                if (cnt_reg == 6'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Operand and partial result registers
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            rem_reg <= '0;
            quo_reg <= '0;
            num_reg <= opa;
            den_reg <= opb;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            num_reg <= num_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign result    = quo_reg;
endmodule

@@ rtl/nbge_mul.sv @@
// ============================================================================
// nbge_mul
// Shared 32x32 multiplier with registered product.
// ============================================================================
module nbge_mul
(
    input  logic        clk,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [63:0] p
);
    logic [63:0] p_reg;

    // Register each product
    always_ff @(posedge clk)
    begin
        p_reg <= 64'(a) * 64'(b);
    end

    assign p = p_reg;
endmodule

@@ rtl/nbody_gravity_euler_step_top.sv @@
// ============================================================================
// nbody_gravity_euler_step_top
// Semi-implicit Euler gravity step for one body under one other body.
// ============================================================================
// A reload, static or self item goes straight to the result state, a singular
// item through the normalise state first. An interaction runs the root and each
// of the four 64-bit divisions on the shared two-bit-per-cycle unit, and the wide
// products are built from 32x32 partial products on one shared multiplier. The
// block takes one item at a time, holds its result until taken and is ready
// again the cycle after.
module nbody_gravity_euler_step_top #(
    parameter int FRAC_BITS = nbge_pkg::FRAC_BITS_D
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [nbge_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [nbge_pkg::WORD_W-1:0]       cfg_data,
    nbge_if.sink                              in_ch,
    nbge_if.source                            out_ch
);
    import nbge_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE, ST_NORM, ST_SQ, ST_SQ_ACC, ST_SQRT, ST_SQRT_W, ST_INV, ST_INV_W,
        ST_W_MUL, ST_W_ACC, ST_G_MUL, ST_G_ACC, ST_U, ST_U_W, ST_UW, ST_UW_ACC,
        ST_GU, ST_GU_ACC, ST_DV, ST_DP_MUL, ST_DP, ST_OUT
    } state_t;

    state_t state_reg;

    // Configuration registers
    logic signed [31:0] start_pos_reg [3];
    logic signed [31:0] start_vel_reg [3];
    logic [31:0]        own_mass_reg;
    logic               is_static_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                start_pos_reg[i] <= '0;
                start_vel_reg[i] <= '0;
            end
            own_mass_reg  <= 32'd65536;
            is_static_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_POS_X:  start_pos_reg[0] <= cfg_data;
                REG_POS_Y:  start_pos_reg[1] <= cfg_data;
                REG_POS_Z:  start_pos_reg[2] <= cfg_data;
                REG_VEL_X:  start_vel_reg[0] <= cfg_data;
                REG_VEL_Y:  start_vel_reg[1] <= cfg_data;
                REG_VEL_Z:  start_vel_reg[2] <= cfg_data;
                REG_MASS:   own_mass_reg     <= cfg_data;
                REG_STATIC: is_static_reg    <= cfg_data[0];
                default:    ;
            endcase
        end
    end

    // Body state and working registers
    logic signed [31:0] pos_reg [3];
    logic signed [31:0] vel_reg [3];
    logic signed [32:0] d_reg [3];
    logic [31:0]        e_reg [3];
    logic signed [7:0]  k_reg;
    logic [63:0]        q_reg;
    logic [63:0]        r_reg;
    logic [63:0]        inv_reg;
    logic [63:0]        w_reg;
    logic [63:0]        g_reg;
    logic [63:0]        u_reg;
    logic [63:0]        uw_reg;
    logic [127:0]       acc_reg;
    logic [1:0]         ax_reg;
    logic [1:0]         pp_reg;
    logic [15:0]        dt_reg;
    logic [31:0]        om_reg;
    logic               sing_reg;
    logic               out_valid_reg;

    // Shared multiplier operand selection
    logic [31:0] ma, mb;
    logic [63:0] mp;
    logic [63:0] mx, my;

    always_comb
    begin
        mx = '0;
        my = '0;
        unique case (state_reg)
            ST_SQ, ST_SQ_ACC:   begin mx = 64'(e_reg[ax_reg]); my = mx; end
            ST_W_MUL, ST_W_ACC: begin mx = inv_reg; my = inv_reg; end
            ST_G_MUL, ST_G_ACC: begin mx = 64'(dt_reg) * 64'(GRAV_CONST); my = 64'(om_reg); end
            ST_UW, ST_UW_ACC:   begin mx = u_reg; my = w_reg; end
            ST_GU, ST_GU_ACC:   begin mx = g_reg; my = uw_reg; end
            ST_DP_MUL, ST_DP:
            begin
                mx = 64'(vel_reg[ax_reg][31] ? -33'(vel_reg[ax_reg]) : 33'(vel_reg[ax_reg]));
                my = 64'(dt_reg);
            end
            default: ;
        endcase
        ma = pp_reg[1] ? mx[63:32] : mx[31:0];
        mb = pp_reg[0] ? my[63:32] : my[31:0];
    end

    nbge_mul u_mul (.clk(clk), .a(ma), .b(mb), .p(mp));

    // Shared root/divide unit
    iter_cmd_t   icmd;
    iter_stat_t  istat;
    logic [63:0] iopa, iopb, ires;

    always_comb
    begin
        icmd.start = 1'b0;
        icmd.op    = OP_SQRT;
        iopa       = q_reg << 12;
        iopb       = '0;
        unique case (state_reg)
            ST_SQRT: icmd.start = 1'b1;
            ST_INV:
            begin
                icmd.start = 1'b1;
                icmd.op    = OP_DIV;
                iopa       = 64'd1 << 60;
                iopb       = r_reg;
            end
            ST_U:
            begin
                icmd.start = 1'b1;
                icmd.op    = OP_DIV;
                iopa       = 64'(e_reg[ax_reg]) << 36;
                iopb       = r_reg;
            end
            default: ;
        endcase
    end

    nbge_iter u_iter (
        .clk(clk), .rst_n(rst_n), .cmd(icmd), .opa(iopa), .opb(iopb),
        .stat(istat), .result(ires)
    );

    // Combinational helpers for the input decode
    logic signed [32:0] dn [3];
    logic [32:0]        mg [3];
    logic [32:0]        smax;
    logic [5:0]         blen;

    always_comb
    begin
        smax = '0;
        for (int i = 0; i < 3; i++)
        begin
            mg[i] = d_reg[i][32] ? 33'(-d_reg[i]) : 33'(d_reg[i]);
            if (mg[i] > smax)
            begin
                smax = mg[i];
            end
        end
        blen = '0;
        for (int j = 0; j < 33; j++)
        begin
            if (smax[j])
            begin
                blen = 6'(j + 1);
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            dn[i] = 33'(in_ch.payload.other_x);
        end
        dn[0] = 33'(in_ch.payload.other_x) - 33'(pos_reg[0]);
        dn[1] = 33'(in_ch.payload.other_y) - 33'(pos_reg[1]);
        dn[2] = 33'(in_ch.payload.other_z) - 33'(pos_reg[2]);
    end

    // Capped shift of the force product
    logic signed [9:0] shamt;
    logic [63:0]       dv_mag;

    always_comb
    begin
        logic [127:0] sh;
        shamt = 10'(124 - 2 * FRAC_BITS) + 10'(2 * k_reg);
        if (shamt >= 10'sd128)
        begin
            sh = '0;
        end
        else if (shamt <= 0)
        begin
            sh = acc_reg;
        end
        else
        begin
            sh = acc_reg >> shamt;
        end
        dv_mag = (sh > (128'd1 << 40)) ? (64'd1 << 40) : sh[63:0];
    end

    function automatic logic signed [31:0] sat32(input logic signed [42:0] v);
        if (v > 43'sd2147483647)
        begin
            return 32'sh7FFFFFFF;
        end
        if (v < -43'sd2147483648)
        begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            sing_reg      <= 1'b0;
            ax_reg        <= '0;
            pp_reg        <= '0;
            for (int i = 0; i < 3; i++)
            begin
                pos_reg[i] <= '0;
                vel_reg[i] <= '0;
            end
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_ch.valid)
                    begin
                        sing_reg <= 1'b0;
                        dt_reg   <= in_ch.payload.step_time;
                        om_reg   <= in_ch.payload.other_mass;
                        for (int i = 0; i < 3; i++)
                        begin
                            d_reg[i] <= dn[i];
                        end
                        if (!in_ch.payload.action)
                        begin
                            for (int i = 0; i < 3; i++)
                            begin
                                pos_reg[i] <= start_pos_reg[i];
                                vel_reg[i] <= start_vel_reg[i];
                            end
                            state_reg <= ST_OUT;
                        end
                        else if (is_static_reg || in_ch.payload.is_self)
                        begin
                            state_reg <= ST_OUT;
                        end
                        else
                        begin
                            state_reg <= ST_NORM;
                        end
                    end
                end
                ST_NORM:
                begin
                    if (own_mass_reg == '0 || smax == '0)
                    begin
                        sing_reg  <= 1'b1;
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        k_reg <= 8'(blen) - 8'(NORM_BITS);
                        for (int i = 0; i < 3; i++)
                        begin
                            e_reg[i] <= (blen >= 6'(NORM_BITS))
                                ? 32'(mg[i] >> (blen - 6'(NORM_BITS)))
                                : 32'(mg[i] << (6'(NORM_BITS) - blen));
                        end
                        q_reg     <= '0;
                        ax_reg    <= '0;
                        pp_reg    <= '0;
                        state_reg <= ST_SQ;
                    end
                end
                // e_i fits 32 bits: one product per axis
                ST_SQ:
                begin
                    state_reg <= ST_SQ_ACC;
                end
                ST_SQ_ACC:
                begin
                    q_reg <= q_reg + mp;
                    if (ax_reg == 2'd2)
                    begin
                        state_reg <= ST_SQRT;
                    end
                    else
                    begin
                        ax_reg    <= ax_reg + 2'd1;
                        state_reg <= ST_SQ;
                    end
                end
                ST_SQRT:
                begin
                    state_reg <= ST_SQRT_W;
                end
                ST_SQRT_W:
                begin
                    if (istat.done)
                    begin
                        r_reg     <= ires;
                        state_reg <= ST_INV;
                    end
                end
                ST_INV:
                begin
                    state_reg <= ST_INV_W;
                end
                ST_INV_W:
                begin
                    if (istat.done)
                    begin
                        inv_reg   <= ires;
                        acc_reg   <= '0;
                        pp_reg    <= '0;
                        state_reg <= ST_W_MUL;
                    end
                end
                // inv^2 over four partial products
                ST_W_MUL:
                begin
                    state_reg <= ST_W_ACC;
                end
                ST_W_ACC:
                begin
                    acc_reg <= acc_reg + (128'(mp) << (32 * (pp_reg[1] + pp_reg[0])));
                    if (pp_reg == 2'd3)
                    begin
                        state_reg <= ST_G_MUL;
                        pp_reg    <= '0;
                    end
                    else
                    begin
                        pp_reg    <= pp_reg + 2'd1;
                        state_reg <= ST_W_MUL;
                    end
                end
                ST_G_MUL:
                begin
                    w_reg     <= acc_reg[93:30];
                    state_reg <= ST_G_ACC;
                end
                ST_G_ACC:
                begin
                    g_reg <= (pp_reg == 2'd0) ? mp : g_reg + (mp << 32);
                    if (pp_reg == 2'd2)
                    begin
                        ax_reg    <= '0;
                        pp_reg    <= '0;
                        state_reg <= ST_U;
                    end
                    else
                    begin
                        pp_reg    <= 2'd2;
                        state_reg <= ST_G_MUL;
                    end
                end
                ST_U:
                begin
                    state_reg <= ST_U_W;
                end
                ST_U_W:
                begin
                    if (istat.done)
                    begin
                        u_reg     <= ires;
                        acc_reg   <= '0;
                        pp_reg    <= '0;
                        state_reg <= ST_UW;
                    end
                end
                // u*w wraps to 64 bits
                ST_UW:
                begin
                    state_reg <= ST_UW_ACC;
                end
                ST_UW_ACC:
                begin
                    if (pp_reg == 2'd2)
                    begin
                        // hold the wrapped product before it feeds the multiplier
                        uw_reg    <= acc_reg[63:0] + (mp << 32);
                        acc_reg   <= '0;
                        state_reg <= ST_GU;
                        pp_reg    <= '0;
                    end
                    else
                    begin
                        acc_reg   <= acc_reg + (128'(mp) << (32 * (pp_reg[1] + pp_reg[0])));
                        pp_reg    <= pp_reg + 2'd1;
                        state_reg <= ST_UW;
                    end
                end
                ST_GU:
                begin
                    state_reg <= ST_GU_ACC;
                end
                ST_GU_ACC:
                begin
                    acc_reg <= acc_reg + (128'(mp) << (32 * (pp_reg[1] + pp_reg[0])));
                    if (pp_reg == 2'd3)
                    begin
                        state_reg <= ST_DV;
                    end
                    else
                    begin
                        pp_reg    <= pp_reg + 2'd1;
                        state_reg <= ST_GU;
                    end
                end
                ST_DV:
                begin
                    vel_reg[ax_reg] <= sat32(d_reg[ax_reg][32]
                        ? 43'(vel_reg[ax_reg]) - 43'(dv_mag[40:0])
                        : 43'(vel_reg[ax_reg]) + 43'(dv_mag[40:0]));
                    pp_reg <= '0;
                    if (ax_reg == 2'd2)
                    begin
                        ax_reg    <= '0;
                        state_reg <= ST_DP_MUL;
                    end
                    else
                    begin
                        ax_reg    <= ax_reg + 2'd1;
                        state_reg <= ST_U;
                    end
                end
                ST_DP_MUL:
                begin
                    state_reg <= ST_DP;
                end
                ST_DP:
                begin
                    pos_reg[ax_reg] <= sat32(vel_reg[ax_reg][31]
                        ? 43'(pos_reg[ax_reg]) - 43'(mp[63:16])
                        : 43'(pos_reg[ax_reg]) + 43'(mp[63:16]));
                    if (ax_reg == 2'd2)
                    begin
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        ax_reg    <= ax_reg + 2'd1;
                        state_reg <= ST_DP_MUL;
                    end
                end
                ST_OUT:
                begin
                    out_valid_reg <= 1'b1;
                    if (out_valid_reg && out_ch.ready)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign in_ch.ready = (state_reg == ST_IDLE);

    // Result fields straight from the body state
    assign out_ch.valid            = out_valid_reg;
    assign out_ch.payload.pos_x    = pos_reg[0];
    assign out_ch.payload.pos_y    = pos_reg[1];
    assign out_ch.payload.pos_z    = pos_reg[2];
    assign out_ch.payload.vel_x    = vel_reg[0];
    assign out_ch.payload.vel_y    = vel_reg[1];
    assign out_ch.payload.vel_z    = vel_reg[2];
    assign out_ch.payload.singular = sing_reg;

    // Checks
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !in_ch.ready) else $error("ready while busy");
    a_out_only_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (state_reg == ST_OUT)) else $error("result outside done");
    a_iter_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        icmd.start |-> !istat.busy) else $error("unit restarted while busy");
endmodule
